/* rtl/core/d8fd_pkg.sv */
package d8fd_pkg;

  localparam int ELEV_WIDTH_DEF = 32;
  localparam int N_LANE = 8;
  localparam int W_FRAC = 16;

  // 1/sqrt2 in Q16
  localparam logic [W_FRAC-1:0] W_DIAG = 16'd46341;

  localparam logic [3:0] DIR_NW      = 4'd0;
  localparam logic [3:0] DIR_W       = 4'd1;
  localparam logic [3:0] DIR_SW      = 4'd2;
  localparam logic [3:0] DIR_N       = 4'd3;
  localparam logic [3:0] CODE_FLAT   = 4'd4;
  localparam logic [3:0] DIR_S       = 4'd5;
  localparam logic [3:0] DIR_NE      = 4'd6;
  localparam logic [3:0] DIR_E       = 4'd7;
  localparam logic [3:0] DIR_SE      = 4'd8;
  localparam logic [3:0] CODE_NODATA = 4'd9;

  // direction code of each lane, lanes in scan order NW N NE W E SW S SE
  localparam logic [3:0] SCAN_CODE [N_LANE] = '{
    DIR_NW, DIR_N, DIR_NE, DIR_W, DIR_E, DIR_SW, DIR_S, DIR_SE
  };

  typedef struct packed {
    logic valid;
    logic nodata;
  } d8fd_ctl_t;

endpackage

/* rtl/core/d8fd_chan_if.sv */
interface d8fd_elev_if import d8fd_pkg::*; #(
  parameter int EW = ELEV_WIDTH_DEF
);
  logic          valid;
  logic          ready;
  logic signed [EW-1:0] elev_north_west;
  logic signed [EW-1:0] elev_north;
  logic signed [EW-1:0] elev_north_east;
  logic signed [EW-1:0] elev_west;
  logic signed [EW-1:0] elev_center;
  logic signed [EW-1:0] elev_east;
  logic signed [EW-1:0] elev_south_west;
  logic signed [EW-1:0] elev_south;
  logic signed [EW-1:0] elev_south_east;

  modport source (
    output valid, elev_north_west, elev_north, elev_north_east, elev_west,
           elev_center, elev_east, elev_south_west, elev_south, elev_south_east,
    input  ready
  );
  modport sink (
    input  valid, elev_north_west, elev_north, elev_north_east, elev_west,
           elev_center, elev_east, elev_south_west, elev_south, elev_south_east,
    output ready
  );
endinterface

interface d8fd_dir_if import d8fd_pkg::*;;
  logic       valid;
  logic       ready;
  logic [3:0] flow_direction;

  modport source (output valid, flow_direction, input ready);
  modport sink (input valid, flow_direction, output ready);
endinterface

/* rtl/core/d8fd_drop.sv */
module d8fd_drop import d8fd_pkg::*; #(
  parameter int EW = ELEV_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  logic                     in_valid,
  input  logic [N_LANE-1:0][EW-1:0] nbr,
  input  logic [EW-1:0]            center,
  input  logic [EW-1:0]            nodata,
  output d8fd_ctl_t                ctl_o,
  output logic [N_LANE-1:0]        lane_v_r,
  output logic [N_LANE-1:0][EW:0]  drop_r
);

  logic                    valid_r;
  logic                    nodata_r;
  logic [N_LANE-1:0]       lane_v_nxt;
  logic [N_LANE-1:0][EW:0] drop_nxt;

  always_comb begin
    for (int n = 0; n < N_LANE; n++) begin
      lane_v_nxt[n] = (nbr[n] != nodata) && ($signed(nbr[n]) < $signed(center));
      // sign-extended difference, positive whenever the lane is below center
      drop_nxt[n]   = {center[EW-1], center} - {nbr[n][EW-1], nbr[n]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      nodata_r <= (center == nodata);
      lane_v_r <= lane_v_nxt;
      drop_r   <= drop_nxt;
    end
  end

  assign ctl_o = '{valid: valid_r, nodata: nodata_r};

endmodule

/* rtl/core/d8fd_weight.sv */
module d8fd_weight import d8fd_pkg::*; #(
  parameter int EW = ELEV_WIDTH_DEF,
  parameter int PW = EW + 1 + W_FRAC
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  d8fd_ctl_t                ctl_i,
  input  logic [N_LANE-1:0]        lane_v_i,
  input  logic [N_LANE-1:0][EW:0]  drop_i,
  output d8fd_ctl_t                ctl_o,
  output logic [N_LANE-1:0][PW-1:0] prod_r,
  output logic [N_LANE-1:0][3:0]   code_r
);

  logic                      valid_r;
  logic                      nodata_r;
  logic [N_LANE-1:0][PW-1:0] prod_nxt;
  logic [N_LANE-1:0][3:0]    code_nxt;

  always_comb begin
    for (int n = 0; n < N_LANE; n++) begin
      if (!lane_v_i[n]) begin
        prod_nxt[n] = '0;
        code_nxt[n] = CODE_FLAT;
      end else if (!SCAN_CODE[n][0]) begin
        // even codes are the diagonals
        prod_nxt[n] = PW'(drop_i[n]) * PW'(W_DIAG);
        code_nxt[n] = SCAN_CODE[n];
      end else begin
        prod_nxt[n] = {drop_i[n], {W_FRAC{1'b0}}};
        code_nxt[n] = SCAN_CODE[n];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && ctl_i.valid) begin
      nodata_r <= ctl_i.nodata;
      prod_r   <= prod_nxt;
      code_r   <= code_nxt;
    end
  end

  assign ctl_o = '{valid: valid_r, nodata: nodata_r};

endmodule

/* rtl/core/d8fd_cmp.sv */
module d8fd_cmp import d8fd_pkg::*; #(
  parameter int PW   = ELEV_WIDTH_DEF + 1 + W_FRAC,
  parameter int NIN  = N_LANE,
  parameter int NOUT = NIN / 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  d8fd_ctl_t             ctl_i,
  input  logic [NIN-1:0][PW-1:0] prod_i,
  input  logic [NIN-1:0][3:0]   code_i,
  output d8fd_ctl_t             ctl_o,
  output logic [NOUT-1:0][PW-1:0] prod_r,
  output logic [NOUT-1:0][3:0]  code_r
);

  logic                     valid_r;
  logic                     nodata_r;
  logic [NOUT-1:0][PW-1:0]  prod_nxt;
  logic [NOUT-1:0][3:0]     code_nxt;

  always_comb begin
    for (int i = 0; i < NOUT; i++) begin
      // later lane wins only on a strictly larger product
      if (prod_i[2*i+1] > prod_i[2*i]) begin
        prod_nxt[i] = prod_i[2*i+1];
        code_nxt[i] = code_i[2*i+1];
      end else begin
        prod_nxt[i] = prod_i[2*i];
        code_nxt[i] = code_i[2*i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && ctl_i.valid) begin
      nodata_r <= ctl_i.nodata;
      prod_r   <= prod_nxt;
      code_r   <= code_nxt;
    end
  end

  assign ctl_o = '{valid: valid_r, nodata: nodata_r};

  for (genvar g = 0; g < NOUT; g++) begin : g_chk
    a_winner_max: assert property (@(posedge clk) disable iff (!rst_n)
      (load && ctl_i.valid) |=>
        (prod_r[g] >= $past(prod_i[2*g])) && (prod_r[g] >= $past(prod_i[2*g+1])))
      else $error("winner below one of its pair");

    a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
      valid_r |-> ((prod_r[g] == '0) == (code_r[g] == CODE_FLAT)))
      else $error("flat code and zero product disagree");
  end

endmodule

/* rtl/core/d8_flow_direction_top.sv */
// channel   port       dir  payload
// input     in_elev    in   3x3 elevation window, ELEV_WIDTH bits signed each
// result    out_dir    out  flow_direction, 4 bits
// config    cfg_we     in   cfg_wdata loads nodata_value
//
// five register stages: drop, weighting multiply, then three compare levels
// one word per cycle sustained while out_dir.ready stays high; a word passes every stage in order before out_dir
// each stage holds its word only while the stage after it is full and stalled,
// so bubbles close up; in_elev.ready falls only when all five stages are full and out_dir waits
// synchronous active-low reset empties the pipe and sets nodata_value to the
// most negative elevation
module d8_flow_direction_top import d8fd_pkg::*; #(
  parameter int ELEV_WIDTH = ELEV_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  d8fd_elev_if.sink             in_elev,
  d8fd_dir_if.source            out_dir,
  input  logic                  cfg_we,
  input  logic [ELEV_WIDTH-1:0] cfg_wdata
);

  localparam int PW = ELEV_WIDTH + 1 + W_FRAC;

  logic [ELEV_WIDTH-1:0]               nodata_r;
  logic [N_LANE-1:0][ELEV_WIDTH-1:0]   nbr;
  d8fd_ctl_t                           ctl1, ctl2, ctl3, ctl4, ctl5;
  logic [N_LANE-1:0]                   lane_v1;
  logic [N_LANE-1:0][ELEV_WIDTH:0]     drop1;
  logic [N_LANE-1:0][PW-1:0]           prod2;
  logic [N_LANE-1:0][3:0]              code2;
  logic [N_LANE/2-1:0][PW-1:0]         prod3;
  logic [N_LANE/2-1:0][3:0]            code3;
  logic [N_LANE/4-1:0][PW-1:0]         prod4;
  logic [N_LANE/4-1:0][3:0]            code4;
  logic [0:0][PW-1:0]                  prod5;
  logic [0:0][3:0]                     code5;
  logic                                rdy1, rdy2, rdy3, rdy4, rdy5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodata_r <= {1'b1, {(ELEV_WIDTH-1){1'b0}}};
    end else if (cfg_we) begin
      nodata_r <= cfg_wdata;
    end
  end

  // scan order NW N NE W E SW S SE
  assign nbr[0] = in_elev.elev_north_west;
  assign nbr[1] = in_elev.elev_north;
  assign nbr[2] = in_elev.elev_north_east;
  assign nbr[3] = in_elev.elev_west;
  assign nbr[4] = in_elev.elev_east;
  assign nbr[5] = in_elev.elev_south_west;
  assign nbr[6] = in_elev.elev_south;
  assign nbr[7] = in_elev.elev_south_east;

  // a stage loads when it is empty or its word moves on
  assign rdy5 = !ctl5.valid || out_dir.ready;
  assign rdy4 = !ctl4.valid || rdy5;
  assign rdy3 = !ctl3.valid || rdy4;
  assign rdy2 = !ctl2.valid || rdy3;
  assign rdy1 = !ctl1.valid || rdy2;

  assign in_elev.ready = rdy1;

  d8fd_drop #(.EW(ELEV_WIDTH)) u_drop (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (rdy1),
    .in_valid (in_elev.valid),
    .nbr      (nbr),
    .center   (in_elev.elev_center),
    .nodata   (nodata_r),
    .ctl_o    (ctl1),
    .lane_v_r (lane_v1),
    .drop_r   (drop1)
  );

  d8fd_weight #(.EW(ELEV_WIDTH), .PW(PW)) u_weight (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (rdy2),
    .ctl_i    (ctl1),
    .lane_v_i (lane_v1),
    .drop_i   (drop1),
    .ctl_o    (ctl2),
    .prod_r   (prod2),
    .code_r   (code2)
  );

  d8fd_cmp #(.PW(PW), .NIN(N_LANE)) u_cmp8 (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (rdy3),
    .ctl_i  (ctl2),
    .prod_i (prod2),
    .code_i (code2),
    .ctl_o  (ctl3),
    .prod_r (prod3),
    .code_r (code3)
  );

  d8fd_cmp #(.PW(PW), .NIN(N_LANE/2)) u_cmp4 (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (rdy4),
    .ctl_i  (ctl3),
    .prod_i (prod3),
    .code_i (code3),
    .ctl_o  (ctl4),
    .prod_r (prod4),
    .code_r (code4)
  );

  d8fd_cmp #(.PW(PW), .NIN(N_LANE/4)) u_cmp2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (rdy5),
    .ctl_i  (ctl4),
    .prod_i (prod4),
    .code_i (code4),
    .ctl_o  (ctl5),
    .prod_r (prod5),
    .code_r (code5)
  );

  assign out_dir.valid          = ctl5.valid;
  assign out_dir.flow_direction = ctl5.nodata ? CODE_NODATA : code5[0];

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl5.valid && !out_dir.ready) |=>
      (ctl5.valid && $stable(code5[0]) && $stable(ctl5.nodata)))
    else $error("stalled output word changed");

  a_flat_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl5.valid && !ctl5.nodata && (code5[0] == CODE_FLAT)) |-> (prod5[0] == '0))
    else $error("flat result with a nonzero drop");

  a_nodata_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_elev.valid && rdy1 && (in_elev.elev_center == nodata_r)) |=>
      (ctl1.valid && ctl1.nodata))
    else $error("nodata center not flagged");

endmodule
